FILE: rtl/core/vlos_pkg.sv
// Shared types and constants for the voxel line-of-sight check unit.
package vlos_pkg;

  // Fixed field widths
  localparam int COORD_W    = 6;
  localparam int LABEL_W    = 2;
  localparam int CFG_W      = 7;
  localparam int CFG_ADDR_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 8;

  // Labels
  localparam logic [LABEL_W-1:0] BACKGROUND_LABEL = 2'd0;
  localparam logic [LABEL_W-1:0] GREY_LABEL       = 2'd3;

  // Operation carried on in_tuser
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_SLICES = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_COLS   = 2'd2;

  localparam logic [CFG_W-1:0] CFG_RESET_SIZE = 7'd64;

  // Which point a scan read refers to
  typedef enum logic [1:0] {
    SEL_EP1    = 2'd0,
    SEL_EP2    = 2'd1,
    SEL_SAMPLE = 2'd2
  } vlos_sel_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      clear;      // write background at the clear address, advance
    logic      load;       // capture the input beat
    logic      mem_write;  // store the captured label
    logic      mul;        // axis setup, first step
    logic      prep;       // axis setup, second step
    logic      issue;      // push one point into the read pipeline
    vlos_sel_t sel;        // which point to push
    logic      out_load;   // load the result register
  } vlos_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clear_last;
    logic pipe_busy;
    logic out_free;
  } vlos_sts_t;

endpackage

FILE: rtl/core/vlos_axis.sv
// One axis of the segment sampler: exact round-half-up stepping of a + (b-a)*m/S.
module vlos_axis #(
  parameter int SAMPLE_STEPS = 50
) (
  input  logic                      clk,
  input  logic [vlos_pkg::COORD_W-1:0] a,
  input  logic [vlos_pkg::COORD_W-1:0] b,
  input  logic                      mul_en,
  input  logic                      prep_en,
  input  logic                      adv,
  output logic [vlos_pkg::COORD_W-1:0] q
);
  import vlos_pkg::*;

  localparam int TWO_S    = 2 * SAMPLE_STEPS;
  localparam int REM_W    = $clog2(TWO_S);
  localparam int MAG_W    = COORD_W + 1;
  localparam int RECIP_SH = $clog2(SAMPLE_STEPS) + 8;
  localparam int RECIP    = (2 ** RECIP_SH + TWO_S - 1) / TWO_S;
  localparam int PROD_W   = MAG_W + RECIP_SH;
  localparam logic [REM_W:0] TWO_S_V = (REM_W + 1)'(TWO_S);

  logic [MAG_W-1:0]   mag2_c;
  logic               neg_c;
  logic [MAG_W-1:0]   mag2_r;
  logic               neg_r;
  logic [PROD_W-1:0]  prod_r;
  logic [MAG_W-1:0]   qa;
  logic [MAG_W-1:0]   ra;
  logic signed [7:0]  qa_s;
  logic signed [7:0]  qd_nxt;
  logic [REM_W-1:0]   rd_nxt;
  logic signed [7:0]  qd_r;
  logic [REM_W-1:0]   rd_r;
  logic [REM_W-1:0]   rem_r;
  logic [COORD_W-1:0] q_r;
  logic [REM_W:0]     sum;
  logic               wrap;
  logic signed [7:0]  q_sum;

  // Twice the distance, split into magnitude and direction
  always_comb begin
    neg_c  = (b < a);
    mag2_c = neg_c ? {a - b, 1'b0} : {b - a, 1'b0};
  end

  // Split the per-step increment 2d into quotient and remainder over 2S
  always_comb begin
    qa   = MAG_W'(prod_r >> RECIP_SH);
    ra   = mag2_r - MAG_W'(qa * TWO_S);
    qa_s = signed'({1'b0, qa});
    if (neg_r && (ra != '0)) begin
      qd_nxt = -qa_s - 8'sd1;
      rd_nxt = REM_W'(TWO_S - int'(ra));
    end else if (neg_r) begin
      qd_nxt = -qa_s;
      rd_nxt = '0;
    end else begin
      qd_nxt = qa_s;
      rd_nxt = REM_W'(ra);
    end
  end

  // Advance one sample: add the remainder, carry into the coordinate
  always_comb begin
    sum   = {1'b0, rem_r} + {1'b0, rd_r};
    wrap  = (sum >= TWO_S_V);
    q_sum = signed'({2'b00, q_r}) + qd_r + (wrap ? 8'sd1 : 8'sd0);
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mag2_r <= mag2_c;
      neg_r  <= neg_c;
      prod_r <= PROD_W'(mag2_c) * PROD_W'(RECIP);
    end
    if (prep_en) begin
      qd_r  <= qd_nxt;
      rd_r  <= rd_nxt;
      q_r   <= a;
      rem_r <= REM_W'(SAMPLE_STEPS);
    end else if (adv) begin
      q_r   <= q_sum[COORD_W-1:0];
      rem_r <= wrap ? REM_W'(sum - TWO_S_V) : REM_W'(sum);
    end
  end

  assign q = q_r;

endmodule

FILE: rtl/core/vlos_datapath.sv
// Datapath: size registers, label memory, point read pipeline and result register.
module vlos_datapath #(
  parameter int MAX_SLICES   = 64,
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int SAMPLE_STEPS = 50
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vlos_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vlos_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_tuser,
  input  logic [vlos_pkg::IN_DATA_W-1:0]  in_tdata,
  input  vlos_pkg::vlos_cmd_t             cmd,
  output vlos_pkg::vlos_sts_t             sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [vlos_pkg::OUT_DATA_W-1:0] out_tdata
);
  import vlos_pkg::*;

  localparam int DEPTH  = MAX_SLICES * MAX_ROWS * MAX_COLS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PLANE  = MAX_ROWS * MAX_COLS;
  localparam logic [8:0] MAX_S_V = 9'(MAX_SLICES);
  localparam logic [8:0] MAX_R_V = 9'(MAX_ROWS);
  localparam logic [8:0] MAX_C_V = 9'(MAX_COLS);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  logic [CFG_W-1:0]   slices_r;
  logic [CFG_W-1:0]   rows_r;
  logic [CFG_W-1:0]   cols_r;

  logic               op_r;
  logic [COORD_W-1:0] as_r, ar_r, ac_r;
  logic [COORD_W-1:0] bs_r, br_r, bc_r;
  logic [LABEL_W-1:0] label_r;

  logic [COORD_W-1:0] qs, qr, qc;
  logic [COORD_W-1:0] ps, pr, pc;
  logic               p_in;
  logic               p_eq;
  logic               adv;

  logic [ADDR_W-1:0]  clr_addr_r;
  logic [LABEL_W-1:0] mem [DEPTH];
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [LABEL_W-1:0] mem_wdata;
  logic               mem_re;
  logic [LABEL_W-1:0] rd_data_r;
  logic               wr_in;

  logic               a_valid_r;
  logic               a_ep_r;
  logic               a_skip_r;
  logic [ADDR_W-1:0]  a_addr_r;
  logic               b_valid_r;
  logic               b_ep_r;
  logic               b_skip_r;
  logic               fail_r;

  logic               out_valid_r;
  logic               out_conn_r;

  function automatic logic in_vol(input logic [COORD_W-1:0] s, input logic [COORD_W-1:0] r,
                                  input logic [COORD_W-1:0] c, input logic [CFG_W-1:0] ls,
                                  input logic [CFG_W-1:0] lr, input logic [CFG_W-1:0] lc);
    in_vol = ({1'b0, s} < ls) && ({1'b0, r} < lr) && ({1'b0, c} < lc) &&
             ({3'b000, s} < MAX_S_V) && ({3'b000, r} < MAX_R_V) && ({3'b000, c} < MAX_C_V);
  endfunction

  function automatic logic [ADDR_W-1:0] vox_addr(input logic [COORD_W-1:0] s,
                                                 input logic [COORD_W-1:0] r,
                                                 input logic [COORD_W-1:0] c);
    vox_addr = ADDR_W'(int'(s) * PLANE + int'(r) * MAX_COLS + int'(c));
  endfunction

  // Size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slices_r <= CFG_RESET_SIZE;
      rows_r   <= CFG_RESET_SIZE;
      cols_r   <= CFG_RESET_SIZE;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SLICES: slices_r <= cfg_wdata;
        CFG_ROWS:   rows_r   <= cfg_wdata;
        CFG_COLS:   cols_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      as_r    <= in_tdata[5:0];
      ar_r    <= in_tdata[11:6];
      ac_r    <= in_tdata[17:12];
      bs_r    <= in_tdata[23:18];
      br_r    <= in_tdata[29:24];
      bc_r    <= in_tdata[35:30];
      label_r <= in_tdata[37:36];
    end
  end

  // Segment samplers, one per axis
  assign adv = cmd.issue && (cmd.sel == SEL_SAMPLE);

  vlos_axis #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_axis_s (
    .clk(clk), .a(as_r), .b(bs_r), .mul_en(cmd.mul), .prep_en(cmd.prep), .adv(adv), .q(qs)
  );
  vlos_axis #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_axis_r (
    .clk(clk), .a(ar_r), .b(br_r), .mul_en(cmd.mul), .prep_en(cmd.prep), .adv(adv), .q(qr)
  );
  vlos_axis #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_axis_c (
    .clk(clk), .a(ac_r), .b(bc_r), .mul_en(cmd.mul), .prep_en(cmd.prep), .adv(adv), .q(qc)
  );

  // Pick the point to read and classify it
  always_comb begin
    case (cmd.sel)
      SEL_EP1: begin
        ps = as_r; pr = ar_r; pc = ac_r;
      end
      SEL_EP2: begin
        ps = bs_r; pr = br_r; pc = bc_r;
      end
      SEL_SAMPLE: begin
        ps = qs; pr = qr; pc = qc;
      end
      default: begin
        ps = as_r; pr = ar_r; pc = ac_r;
      end
    endcase
    p_in = in_vol(ps, pr, pc, slices_r, rows_r, cols_r);
    p_eq = ((ps == as_r) && (pr == ar_r) && (pc == ac_r)) ||
           ((ps == bs_r) && (pr == br_r) && (pc == bc_r));
  end

  // Read pipeline stage A: address and skip flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= cmd.issue;
    end
    a_ep_r   <= (cmd.sel != SEL_SAMPLE);
    a_skip_r <= !p_in || ((cmd.sel == SEL_SAMPLE) && p_eq);
    a_addr_r <= vox_addr(ps, pr, pc);
  end

  // Label memory: clear sweep and label writes on one port, reads from stage A
  assign wr_in     = in_vol(as_r, ar_r, ac_r, slices_r, rows_r, cols_r);
  assign mem_we    = cmd.clear || (cmd.mem_write && wr_in);
  assign mem_waddr = cmd.clear ? clr_addr_r : vox_addr(as_r, ar_r, ac_r);
  assign mem_wdata = cmd.clear ? BACKGROUND_LABEL : label_r;
  assign mem_re    = a_valid_r && !a_skip_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[a_addr_r];
    end
  end

  // Clear sweep address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clear) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Stage B: judge the label read back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      fail_r    <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
      if (cmd.load) begin
        fail_r <= 1'b0;
      end else if (b_valid_r) begin
        if (b_ep_r && (b_skip_r || (rd_data_r == BACKGROUND_LABEL))) begin
          fail_r <= 1'b1;
        end else if (!b_ep_r && !b_skip_r && (rd_data_r != GREY_LABEL)) begin
          fail_r <= 1'b1;
        end
      end
    end
    b_ep_r   <= a_ep_r;
    b_skip_r <= a_skip_r;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_conn_r <= (op_r == OP_QUERY) && !fail_r;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_tdata      = {(OUT_DATA_W - 1)'(0), out_conn_r};
  assign sts.clear_last = (clr_addr_r == LAST_ADDR);
  assign sts.pipe_busy  = a_valid_r || b_valid_r;
  assign sts.out_free   = !out_valid_r || out_tready;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over an unread beat");
  a_no_write_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r || b_valid_r) |-> !mem_we)
    else $error("label memory written during a query scan");
  a_write_answers_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && (op_r == OP_WRITE)) |=> !out_conn_r)
    else $error("write beat answered connected");
`endif

endmodule

FILE: rtl/core/vlos_ctrl.sv
// Controller: sequences clear sweep, label writes and query scans.
module vlos_ctrl #(
  parameter int SAMPLE_STEPS = 50
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tuser,
  output logic                in_tready,
  input  vlos_pkg::vlos_sts_t sts,
  output vlos_pkg::vlos_cmd_t cmd
);
  import vlos_pkg::*;

  localparam int LAST_ISSUE = SAMPLE_STEPS + 2;
  localparam int CNT_W      = $clog2(SAMPLE_STEPS + 3);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(LAST_ISSUE);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_WRITE = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_PREP  = 8'b0001_0000,
    ST_SCAN  = 8'b0010_0000,
    ST_DRAIN = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.sel   = SEL_EP1;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = (in_tuser == OP_QUERY) ? ST_MUL : ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.mem_write = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (cnt_r == CNT_W'(0)) begin
          cmd.sel = SEL_EP1;
        end else if (cnt_r == CNT_W'(1)) begin
          cmd.sel = SEL_EP2;
        end else begin
          cmd.sel = SEL_SAMPLE;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_CNT) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !sts.pipe_busy)
    else $error("input taken while reads are in flight");
  a_issue_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue |-> (cnt_r <= LAST_CNT))
    else $error("scan counter ran past the last sample");
  a_scan_then_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.issue && (cnt_r == LAST_CNT)) |=> (state_r == ST_DRAIN))
    else $error("scan did not end after the last sample");
`endif

endmodule

FILE: rtl/core/voxel_line_of_sight_check_unit.sv
// Top level of the voxel line-of-sight check unit.
//
// Input beats on in_*: in_tuser selects a label write (0) or a segment query (1).
// A write stores the label at the first voxel when it lies inside the sizes in
// use and answers connected = 0. A query answers 1 when both endpoints lie in the
// volume and are not background and every sample of the segment (SAMPLE_STEPS+1
// points, rounded half up) that is inside the volume and not an endpoint holds
// grey matter. Every input beat gives exactly one output beat on out_*.
// Sizes are set through cfg_we/cfg_addr/cfg_wdata; the user must write them only
// while the unit is idle, as the unit itself does not enforce this.
// A query reads both endpoints and then one sample point per cycle through the
// single read port of the label memory.
// One beat is in work at a time; the next is accepted once the result sits in
// the output register, so a stalled receiver holds at most one beat there.
// After reset the label memory is swept to background, one voxel per cycle,
// over all MAX_SLICES*MAX_ROWS*MAX_COLS voxels (262144 at the defaults); in_tready
// stays low during the sweep, while configuration writes are taken as always.
module voxel_line_of_sight_check_unit #(
  parameter int MAX_SLICES   = 64,
  parameter int MAX_ROWS     = 64,
  parameter int MAX_COLS     = 64,
  parameter int SAMPLE_STEPS = 50
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vlos_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vlos_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [5:0] first_slice, [11:6] first_row, [17:12] first_col, [23:18] second_slice,
  // [29:24] second_row, [35:30] second_col, [37:36] label, [39:38] zero
  input  logic [vlos_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] operation
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] connected, [7:1] zero
  output logic [vlos_pkg::OUT_DATA_W-1:0] out_tdata
);
  import vlos_pkg::*;

  vlos_cmd_t cmd;
  vlos_sts_t sts;

  vlos_ctrl #(.SAMPLE_STEPS(SAMPLE_STEPS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  vlos_datapath #(
    .MAX_SLICES   (MAX_SLICES),
    .MAX_ROWS     (MAX_ROWS),
    .MAX_COLS     (MAX_COLS),
    .SAMPLE_STEPS (SAMPLE_STEPS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: dv/vlos_result_checker.sv
// Result checker for the voxel line-of-sight unit: tracks the label volume and compares beats.
`timescale 1ns / 1ps

module vlos_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [vlos_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [vlos_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [vlos_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [vlos_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            run_over,
  output int unsigned                     mismatch_count
);
  import vlos_pkg::*;

  localparam int unsigned MAX_SLICES = 64;
  localparam int unsigned MAX_ROWS   = 64;
  localparam int unsigned MAX_COLS   = 64;
  localparam int unsigned STEPS      = 50;
  localparam int unsigned VOXELS     = MAX_SLICES * MAX_ROWS * MAX_COLS;

  // in_tdata layout, lowest field last
  typedef struct packed {
    logic [1:0]         pad;
    logic [LABEL_W-1:0] label;
    logic [COORD_W-1:0] second_col;
    logic [COORD_W-1:0] second_row;
    logic [COORD_W-1:0] second_slice;
    logic [COORD_W-1:0] first_col;
    logic [COORD_W-1:0] first_row;
    logic [COORD_W-1:0] first_slice;
  } voxel_beat_t;

  logic [LABEL_W-1:0] label_volume [VOXELS];
  logic [CFG_W-1:0]   slices_in_use;
  logic [CFG_W-1:0]   rows_in_use;
  logic [CFG_W-1:0]   cols_in_use;
  logic               connected_q [$];
  int unsigned        errors = 0;
  bit                 closed = 1'b0;

  assign mismatch_count = errors;

  // Clamp a size register to the volume dimension
  function automatic int unsigned axis_span(logic [CFG_W-1:0] size, int unsigned max_size);
    return (size > max_size) ? max_size : int'(size);
  endfunction

  function automatic bit in_volume(int s, int r, int c);
    return s < int'(axis_span(slices_in_use, MAX_SLICES)) &&
           r < int'(axis_span(rows_in_use, MAX_ROWS)) &&
           c < int'(axis_span(cols_in_use, MAX_COLS));
  endfunction

  function automatic int voxel_index(int s, int r, int c);
    return (s * MAX_ROWS + r) * MAX_COLS + c;
  endfunction

  // a + (b-a)*m/STEPS, rounded half up in exact integers
  function automatic int round_half_up(int a, int b, int m);
    return (2 * a * STEPS + 2 * (b - a) * m + STEPS) / (2 * STEPS);
  endfunction

  // Ends must be in the volume and not background; any non-grey interior sample breaks it
  function automatic logic predict_connected(voxel_beat_t q);
    int s1, r1, c1, s2, r2, c2;
    int s, r, c, m;
    s1 = int'(q.first_slice);
    r1 = int'(q.first_row);
    c1 = int'(q.first_col);
    s2 = int'(q.second_slice);
    r2 = int'(q.second_row);
    c2 = int'(q.second_col);
    if (!in_volume(s1, r1, c1) || !in_volume(s2, r2, c2)) return 1'b0;
    if (label_volume[voxel_index(s1, r1, c1)] == BACKGROUND_LABEL) return 1'b0;
    if (label_volume[voxel_index(s2, r2, c2)] == BACKGROUND_LABEL) return 1'b0;
    for (m = 0; m <= int'(STEPS); m++) begin
      s = round_half_up(s1, s2, m);
      r = round_half_up(r1, r2, m);
      c = round_half_up(c1, c2, m);
      if (!in_volume(s, r, c)) continue;
      if (s == s1 && r == r1 && c == c1) continue;
      if (s == s2 && r == r2 && c == c2) continue;
      if (label_volume[voxel_index(s, r, c)] != GREY_LABEL) return 1'b0;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    voxel_beat_t beat;
    logic        hope;
    if (!rst_n) begin
      for (int i = 0; i < int'(VOXELS); i++) label_volume[i] = BACKGROUND_LABEL;
      slices_in_use = CFG_RESET_SIZE;
      rows_in_use   = CFG_RESET_SIZE;
      cols_in_use   = CFG_RESET_SIZE;
      connected_q.delete();
    end else begin
      // Track size registers
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SLICES: slices_in_use = cfg_wdata;
          CFG_ROWS:   rows_in_use   = cfg_wdata;
          CFG_COLS:   cols_in_use   = cfg_wdata;
          default: ;
        endcase
      end

      // Compare a result beat against the oldest prediction
      if (out_tvalid && out_tready) begin
        if (connected_q.size() == 0) begin
          $display("%0t ns: result beat with nothing outstanding, expected none, actual %0d",
                   $time, out_tdata[0]);
          errors++;
        end else begin
          hope = connected_q.pop_front();
          if (out_tdata[0] !== hope) begin
            $display("%0t ns: connected mismatch, expected %0d, actual %0d",
                     $time, hope, out_tdata[0]);
            errors++;
          end
        end
      end

      // Apply an input beat to the volume copy and predict its result
      if (in_tvalid && in_tready) begin
        beat = voxel_beat_t'(in_tdata);
        if (in_tuser == OP_WRITE) begin
          if (in_volume(int'(beat.first_slice), int'(beat.first_row), int'(beat.first_col)))
            label_volume[voxel_index(int'(beat.first_slice), int'(beat.first_row),
                                     int'(beat.first_col))] = beat.label;
          connected_q.push_back(1'b0);
        end else begin
          connected_q.push_back(predict_connected(beat));
        end
      end

      // Flag predictions that never got a result
      if (run_over && !closed) begin
        closed = 1'b1;
        if (connected_q.size() != 0) begin
          $display("%0t ns: results missing, expected 0 outstanding, actual %0d",
                   $time, connected_q.size());
          errors += connected_q.size();
        end
      end
    end
  end

endmodule

FILE: dv/tb_top.sv
// Testbench top for the voxel line-of-sight unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import vlos_pkg::*;

  localparam int unsigned ITEMS = 700;
  localparam logic [LABEL_W-1:0] RIM_LOW_LABEL  = 2'd1;
  localparam logic [LABEL_W-1:0] RIM_HIGH_LABEL = 2'd2;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = CFG_SLICES;
  logic [CFG_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [5:0] first_slice, [11:6] first_row, [17:12] first_col, [23:18] second_slice,
  // [29:24] second_row, [35:30] second_col, [37:36] label, [39:38] zero
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  // [0] operation
  logic                  in_tuser   = OP_WRITE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [0] connected, [7:1] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  run_over   = 1'b0;
  int unsigned           mismatch_count;

  int unsigned n_sent   = 0;
  int unsigned n_seen   = 0;
  bit          idle_on  = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned use_dim [3];

  always #2 clk = ~clk;

  voxel_line_of_sight_check_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  vlos_result_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .run_over       (run_over),
    .mismatch_count (mismatch_count)
  );

  // Count result beats so phases can wait for the unit to drain
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) n_seen <= n_seen + 1;
  end

  // Receiver: random stall bursts, plus a long hold-off on request
  initial begin
    int unsigned n;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 4);
        repeat (n) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one beat, with an optional gap first; valid stays up after the handshake
  task automatic send_beat(input logic op, input logic [5:0] s1, r1, c1, s2, r2, c2,
                           input logic [1:0] lab);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, lab, c2, r2, s2, c1, r1, s1};
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic write_label(input logic [5:0] s, r, c, input logic [1:0] lab);
    send_beat(OP_WRITE, s, r, c, 6'($urandom), 6'($urandom), 6'($urandom), lab);
  endtask

  task automatic ask_segment(input logic [5:0] s1, r1, c1, s2, r2, c2);
    send_beat(OP_QUERY, s1, r1, c1, s2, r2, c2, 2'($urandom));
  endtask

  // Drop valid and wait until every beat has produced its result
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (n_seen < n_sent);
    repeat (4) @(posedge clk);
  endtask

  // Program all three sizes once the unit is idle
  task automatic set_sizes(input logic [6:0] s, r, c);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SLICES;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_addr  <= CFG_ROWS;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_addr  <= CFG_COLS;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    use_dim[0] = 32'(s);
    use_dim[1] = 32'(r);
    use_dim[2] = 32'(c);
  endtask

  function automatic logic [6:0] pick_size();
    case ($urandom_range(0, 15))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd64;
      3:       return 7'd127;
      4:       return 7'($urandom_range(65, 126));
      5, 6:    return 7'($urandom_range(2, 63));
      default: return 7'($urandom_range(2, 6));
    endcase
  endfunction

  // Fill a small box (long along one axis) mostly grey, then query segments from it
  task automatic grey_box_episode();
    int unsigned lo [3];
    int unsigned hi [3];
    int unsigned lim, ext, long_axis, n_ask;
    int unsigned k, j, s, r, c;
    logic [5:0]  a [3];
    logic [5:0]  b [3];
    logic [1:0]  lab;
    long_axis = $urandom_range(0, 2);
    for (k = 0; k < 3; k++) begin
      lim   = (use_dim[k] == 0 || use_dim[k] > 64) ? 64 : use_dim[k];
      ext   = (k == long_axis) ? $urandom_range(1, 10) : $urandom_range(1, 2);
      lo[k] = $urandom_range(0, lim - 1);
      hi[k] = (lo[k] + ext - 1 > 63) ? 63 : lo[k] + ext - 1;
    end
    for (s = lo[0]; s <= hi[0]; s++)
      for (r = lo[1]; r <= hi[1]; r++)
        for (c = lo[2]; c <= hi[2]; c++) begin
          lab = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 2)) : GREY_LABEL;
          write_label(6'(s), 6'(r), 6'(c), lab);
        end
    n_ask = $urandom_range(2, 6);
    for (j = 0; j < n_ask; j++) begin
      for (k = 0; k < 3; k++) begin
        a[k] = 6'($urandom_range(lo[k], hi[k]));
        b[k] = 6'($urandom_range(lo[k], hi[k]));
      end
      // now and then aim the far end anywhere
      if ($urandom_range(0, 7) == 0)
        for (k = 0; k < 3; k++) b[k] = 6'($urandom);
      ask_segment(a[0], a[1], a[2], b[0], b[1], b[2]);
    end
  endtask

  initial begin
    logic [6:0]  sz_s, sz_r, sz_c;
    int unsigned phase;
    int unsigned n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, rims in the path, background ends, size edges
    ask_segment(0, 0, 0, 63, 63, 63);
    write_label(0, 0, 0, GREY_LABEL);
    write_label(63, 63, 63, GREY_LABEL);
    ask_segment(0, 0, 0, 0, 0, 0);
    ask_segment(63, 63, 63, 0, 0, 0);
    write_label(0, 0, 1, RIM_LOW_LABEL);
    write_label(0, 0, 2, GREY_LABEL);
    ask_segment(0, 0, 0, 0, 0, 1);
    ask_segment(0, 0, 0, 0, 0, 2);
    write_label(0, 0, 1, GREY_LABEL);
    ask_segment(0, 0, 2, 0, 0, 0);
    write_label(0, 1, 0, RIM_HIGH_LABEL);
    ask_segment(0, 1, 0, 0, 1, 0);
    ask_segment(0, 1, 0, 0, 0, 2);
    write_label(0, 0, 0, BACKGROUND_LABEL);
    ask_segment(0, 0, 2, 0, 0, 0);
    set_sizes(7'd64, 7'd64, 7'd2);
    write_label(0, 0, 5, GREY_LABEL);
    ask_segment(0, 0, 1, 0, 0, 2);
    ask_segment(0, 0, 1, 0, 0, 1);
    set_sizes(7'd0, 7'd64, 7'd2);
    write_label(0, 0, 0, GREY_LABEL);
    ask_segment(0, 0, 1, 0, 0, 1);
    set_sizes(7'd127, 7'd127, 7'd127);
    ask_segment(63, 63, 63, 63, 63, 63);
    ask_segment(0, 0, 5, 0, 0, 5);
    ask_segment(0, 0, 0, 0, 0, 0);

    // Random phases: new sizes, grey boxes with queries, scattered noise beats
    phase = 0;
    while (n_sent < ITEMS) begin
      case (phase)
        0:       begin sz_s = 7'd64;  sz_r = 7'd64; sz_c = 7'd64; end
        1:       begin sz_s = 7'd1;   sz_r = 7'd1;  sz_c = 7'd1;  end
        2:       begin sz_s = 7'd127; sz_r = 7'd64; sz_c = 7'd2;  end
        3:       begin sz_s = 7'd3;   sz_r = 7'd3;  sz_c = 7'd3;  end
        default: begin sz_s = pick_size(); sz_r = pick_size(); sz_c = pick_size(); end
      endcase
      set_sizes(sz_s, sz_r, sz_c);
      // long receiver hold-off while beats keep coming
      if (phase == 3 || phase == 8) hold_req = 1'b1;
      repeat (5) begin
        idle_on = (phase % 4 != 2) && (n_sent + 60 < ITEMS);
        grey_box_episode();
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 3);
          repeat (n)
            send_beat(1'($urandom), 6'($urandom), 6'($urandom), 6'($urandom),
                      6'($urandom), 6'($urandom), 6'($urandom), 2'($urandom));
        end
      end
      phase++;
    end

    // Drain, let the pipeline settle, then give the verdict
    idle_on = 1'b0;
    wait_drained();
    repeat (70) @(posedge clk);
    run_over <= 1'b1;
    repeat (2) @(posedge clk);
    if (mismatch_count == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Hard stop: covers the post-reset clearing sweep several times over
  initial begin
    #8_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
